FILE: design/wsd_pkg.sv
// wsd_pkg: shared types and constants for the websocket frame deframer
// no dependencies; used by wsd_in_stage, wsd_core and websocket_frame_deframer
`default_nettype none

package wsd_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int CFG_W           = 21;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 21'd8192;

    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;
    localparam logic [3:0] MASK_BYTES   = 4'd4;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_CLOSE    = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_EMPTY    = 2'd3
    } t_kind;

    typedef enum logic [6:0] {
        PH_HDR0   = 7'b0000001,
        PH_HDR1   = 7'b0000010,
        PH_EXT    = 7'b0000100,
        PH_MASK   = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_CLOSED = 7'b0100000,
        PH_DEAD   = 7'b1000000
    } t_phase;

    // registered input beat handed from the input stage to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_beat;

endpackage

`default_nettype wire

FILE: design/websocket_frame_deframer.sv
// websocket_frame_deframer: top level, limit register and the two stages
// depends on wsd_pkg, wsd_in_stage, wsd_core
//
//  channel  direction  handshake                      payload
//  in       sink       i_in_valid / o_in_stall        i_in_byte
//  out      source     o_out_valid / i_out_stall      o_kind, o_out_byte, o_last_of_frame
//  cfg      sink       i_cfg_valid / o_cfg_ready      i_cfg_data (max payload length)
//
// one byte per cycle sustained while i_out_stall is low: a beat lands in the input
// register at its accept edge and the parser writes its result to the result register
// synchronous active-low reset returns to the first header byte, limit 8192
// a stall on a waiting result holds the result register and the input register;
// the input takes a new beat whenever its register empties in the same cycle
// the limit register always takes writes
`default_nettype none

module websocket_frame_deframer #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_in_byte,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_frame,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [wsd_pkg::CFG_W-1:0] i_cfg_data
);

    logic [wsd_pkg::CFG_W-1:0] r_max_len;
    wsd_pkg::t_in_beat         beat;
    logic                      take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= wsd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    wsd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .o_in_stall (o_in_stall),
        .i_take     (take),
        .o_beat     (beat)
    );

    wsd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beat          (beat),
        .i_max_len       (r_max_len),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire

FILE: design/wsd_in_stage.sv
// wsd_in_stage: input register for received bytes, drives the input stall
// depends on wsd_pkg (t_in_beat)
`default_nettype none

module wsd_in_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [7:0]       i_in_byte,
    output logic                  o_in_stall,
    input  wire logic             i_take,
    output wsd_pkg::t_in_beat     o_beat
);

    logic       r_valid;
    logic [7:0] r_data;

    // hold the beat until the parser takes it
    assign o_in_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_data <= i_in_byte;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

`default_nettype wire

FILE: design/wsd_core.sv
// wsd_core: frame header parser, unmasking and result register
// depends on wsd_pkg (phase and kind types, header constants)
`default_nettype none

module wsd_core #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire wsd_pkg::t_in_beat         i_beat,
    input  wire logic [wsd_pkg::CFG_W-1:0] i_max_len,
    output logic                           o_take,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_frame
);

    localparam int CMP_W = (LENGTH_BITS > wsd_pkg::CFG_W) ? LENGTH_BITS : wsd_pkg::CFG_W;

    wsd_pkg::t_phase        r_phase, n_phase;
    logic [3:0]             r_count, n_count;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [31:0]            r_key, n_key;
    logic [1:0]             r_idx, n_idx;

    logic                   r_out_valid;
    wsd_pkg::t_kind         r_kind;
    logic [7:0]             r_out_byte;
    logic                   r_last;

    logic                   emit;
    wsd_pkg::t_kind         emit_kind;
    logic [7:0]             emit_byte;
    logic                   emit_last;

    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] ext_len;
    logic [LENGTH_BITS-1:0] done_len;
    logic                   oversize;
    logic [3:0]             count_dec;
    logic [7:0]             key_byte;

    assign o_take = !r_out_valid || !i_out_stall;
    assign b      = i_beat.data;

    // extended length shifts in big-endian, saturating when bits would fall off the top
    always_comb begin
        if (r_len[LENGTH_BITS-1 -: 8] != 8'd0) begin
            ext_len = '1;
        end else begin
            ext_len = {r_len[LENGTH_BITS-9:0], b};
        end
    end

    // length that is complete this beat: short form from header byte 1 or the extended one
    assign done_len  = r_phase[1] ? LENGTH_BITS'(b[6:0]) : ext_len;
    assign oversize  = CMP_W'(done_len) > CMP_W'(i_max_len);
    assign count_dec = r_count - 4'd1;

    always_comb begin
        case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_len     = r_len;
        n_rem     = r_rem;
        n_key     = r_key;
        n_idx     = r_idx;
        emit      = 1'b0;
        emit_kind = wsd_pkg::KIND_DATA;
        emit_byte = 8'd0;
        emit_last = 1'b0;
        if (o_take && i_beat.valid) begin
            case (r_phase)
                wsd_pkg::PH_HDR0: begin
                    if (b[3:0] == wsd_pkg::OPCODE_CLOSE) begin
                        n_phase   = wsd_pkg::PH_CLOSED;
                        emit      = 1'b1;
                        emit_kind = wsd_pkg::KIND_CLOSE;
                    end else begin
                        n_phase = wsd_pkg::PH_HDR1;
                    end
                end
                wsd_pkg::PH_HDR1: begin
                    n_len = '0;
                    n_idx = 2'd0;
                    if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
                        n_phase = wsd_pkg::PH_EXT;
                        n_count = wsd_pkg::EXT16_BYTES;
                    end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
                        n_phase = wsd_pkg::PH_EXT;
                        n_count = wsd_pkg::EXT64_BYTES;
                    end else begin
                        n_len = done_len;
                        if (oversize) begin
                            n_phase   = wsd_pkg::PH_DEAD;
                            emit      = 1'b1;
                            emit_kind = wsd_pkg::KIND_OVERSIZE;
                        end else begin
                            n_phase = wsd_pkg::PH_MASK;
                            n_count = wsd_pkg::MASK_BYTES;
                            n_key   = '0;
                        end
                    end
                end
                wsd_pkg::PH_EXT: begin
                    n_len   = ext_len;
                    n_count = count_dec;
                    if (count_dec == 4'd0) begin
                        if (oversize) begin
                            n_phase   = wsd_pkg::PH_DEAD;
                            emit      = 1'b1;
                            emit_kind = wsd_pkg::KIND_OVERSIZE;
                        end else begin
                            n_phase = wsd_pkg::PH_MASK;
                            n_count = wsd_pkg::MASK_BYTES;
                            n_key   = '0;
                        end
                    end
                end
                wsd_pkg::PH_MASK: begin
                    n_key   = {r_key[23:0], b};
                    n_count = count_dec;
                    if (count_dec == 4'd0) begin
                        n_idx = 2'd0;
                        if (r_len == '0) begin
                            n_phase   = wsd_pkg::PH_HDR0;
                            emit      = 1'b1;
                            emit_kind = wsd_pkg::KIND_EMPTY;
                        end else begin
                            n_rem   = r_len;
                            n_phase = wsd_pkg::PH_DATA;
                        end
                    end
                end
                wsd_pkg::PH_DATA: begin
                    n_idx     = r_idx + 2'd1;
                    n_rem     = r_rem - LENGTH_BITS'(1);
                    emit      = 1'b1;
                    emit_kind = wsd_pkg::KIND_DATA;
                    emit_byte = b ^ key_byte;
                    // last byte when the count runs out
                    if (r_rem == LENGTH_BITS'(1)) begin
                        emit_last = 1'b1;
                        n_phase   = wsd_pkg::PH_HDR0;
                    end
                end
                default: begin
                    // closed or dead: bytes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsd_pkg::PH_HDR0;
            r_count     <= 4'd0;
            r_len       <= '0;
            r_rem       <= '0;
            r_key       <= '0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_key   <= n_key;
            r_idx   <= n_idx;
            if (o_take) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind     <= emit_kind;
            r_out_byte <= emit_byte;
            r_last     <= emit_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_frame = r_last;

endmodule

`default_nettype wire
